// ===== hw/rtl/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared widths, register indexes and control types for the ghash accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ghash_pkg;

    localparam int HALF_W  = 64;
    localparam int BLOCK_W = 2 * HALF_W;
    localparam int BYTES   = BLOCK_W / 8;
    localparam int COUNT_W = 5;

    // carry-less product of two field elements before reduction
    localparam int PROD_W = 2 * BLOCK_W - 1;

    // reduction byte of the reflected field polynomial x^128 + x^7 + x^2 + x + 1
    localparam logic [7:0] GF_REDUCE_BYTE = 8'hE1;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SUBKEY_HIGH = 1'b0,
        CFG_SUBKEY_LOW  = 1'b1
    } cfg_index_t;

    // control of the item held in the input register
    typedef struct packed {
        logic valid;
        logic restart;
    } item_ctrl_t;

endpackage : ghash_pkg

`default_nettype wire

// ===== hw/rtl/ghash_input_stage.sv =====
// ----------------------------------------------------------------------------
// ghash_input_stage
// Input register: masks bytes past the count and holds the block for one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ghash_input_stage
    import ghash_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_restart,
    input  wire logic [BLOCK_W-1:0] in_block,
    input  wire logic [COUNT_W-1:0] in_count,
    input  wire logic               advance,
    output item_ctrl_t              ctrl,
    output logic      [BLOCK_W-1:0] block
);

    logic               valid_reg, valid_next;
    logic               restart_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [BLOCK_W-1:0] masked;
    logic               load;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    // byte 0 sits in the top bits; a count of 16 or more keeps every byte
    always_comb begin
        masked = in_block;
        for (int j = 0; j < BYTES; j++) begin
            if (COUNT_W'(j) >= in_count) begin
                masked[BLOCK_W-1-8*j -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            restart_reg <= in_restart;
            block_reg   <= masked;
        end
    end

    assign ctrl.valid   = valid_reg;
    assign ctrl.restart = restart_reg;
    assign block        = block_reg;

endmodule : ghash_input_stage

`default_nettype wire

// ===== hw/rtl/ghash_gf_mult.sv =====
// ----------------------------------------------------------------------------
// ghash_gf_mult
// Parallel GF(2^128) multiplier in the reflected GCM bit order.
// ----------------------------------------------------------------------------
`default_nettype none

module ghash_gf_mult
    import ghash_pkg::*;
(
    input  wire logic [BLOCK_W-1:0] x_in,
    input  wire logic [BLOCK_W-1:0] h_in,
    output logic      [BLOCK_W-1:0] z_out
);

    // coefficient of x^i is vector bit BLOCK_W-1-i
    logic [BLOCK_W-1:0] a_coef;
    logic [BLOCK_W-1:0] b_coef;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  red;

    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            a_coef[i] = x_in[BLOCK_W-1-i];
            b_coef[i] = h_in[BLOCK_W-1-i];
        end
    end

    // carry-less product, one xor tree per coefficient
    always_comb begin
        prod = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            for (int j = 0; j < BLOCK_W; j++) begin
                prod[i+j] = prod[i+j] ^ (a_coef[i] & b_coef[j]);
            end
        end
    end

    // fold high terms down, top first, since the x^7 term can land above x^127
    always_comb begin
        red = prod;
        for (int k = PROD_W - 1; k >= BLOCK_W; k--) begin
            for (int t = 0; t < 8; t++) begin
                if (GF_REDUCE_BYTE[7-t]) begin
                    red[k-BLOCK_W+t] = red[k-BLOCK_W+t] ^ red[k];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            z_out[BLOCK_W-1-i] = red[i];
        end
    end

endmodule : ghash_gf_mult

`default_nettype wire

// ===== hw/rtl/ghash_accumulator.sv =====
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH accumulator: xor a block into the state and multiply by H.
// ----------------------------------------------------------------------------
// Takes one 16-byte block per transfer and returns the updated 128-bit GHASH
// state after every block. One block per clock is sustained while m_tready is
// high: a transfer lands in the input register, then a full parallel GF(2^128)
// multiplier computes (state ^ block) * H straight into the state register,
// which is also the result register. The input register accepts a new block
// while a result waits on m_tready, so the slave side stalls only once both
// stages are full. Bytes past the count are zero (a count of 0 still multiplies
// by H; counts above 16 use the whole block). tuser set on a block clears the
// state first. H is written through the config port in two big-endian halves
// by the user only while idle; the block itself does not enforce this.
`default_nettype none

module ghash_accumulator
    import ghash_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [135:0]       s_tdata,  // block_high, block_low, valid_bytes, zero pad
    input  wire logic               s_tuser,  // restart
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [BLOCK_W-1:0]      m_tdata,  // digest_high, digest_low
    // config write port
    input  wire logic               cfg_wr_en,
    input  wire logic [0:0]         cfg_wr_index,
    input  wire logic [HALF_W-1:0]  cfg_wr_data
);

    logic [HALF_W-1:0]  subkey_high_reg;
    logic [HALF_W-1:0]  subkey_low_reg;
    logic [BLOCK_W-1:0] acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;

    item_ctrl_t         s1_ctrl;
    logic [BLOCK_W-1:0] s1_block;
    logic [BLOCK_W-1:0] mult_in;
    logic [BLOCK_W-1:0] product;
    logic               out_load;
    cfg_index_t         cfg_sel;

    // result register is free or being drained this cycle
    assign out_load = s1_ctrl.valid && (!m_valid_reg || m_tready);

    // unpack input: high half first in the vector, byte 0 at the top
    ghash_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_restart (s_tuser),
        .in_block   ({s_tdata[63:0], s_tdata[127:64]}),
        .in_count   (s_tdata[132:128]),
        .advance    (out_load),
        .ctrl       (s1_ctrl),
        .block      (s1_block)
    );

    // restart drops the old state before absorbing the block
    assign mult_in = (s1_ctrl.restart ? '0 : acc_reg) ^ s1_block;

    ghash_gf_mult u_mult (
        .x_in  (mult_in),
        .h_in  ({subkey_high_reg, subkey_low_reg}),
        .z_out (product)
    );

    // state advances only when its result moves into the result register
    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            acc_next     = product;
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // subkey halves
    assign cfg_sel = cfg_index_t'(cfg_wr_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subkey_high_reg <= '0;
            subkey_low_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_sel)
                CFG_SUBKEY_HIGH: begin
                    subkey_high_reg <= cfg_wr_data;
                end
                CFG_SUBKEY_LOW: begin
                    subkey_low_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {acc_reg[HALF_W-1:0], acc_reg[BLOCK_W-1:HALF_W]};

endmodule : ghash_accumulator

`default_nettype wire
